FILE: sv/tss_pkg.sv
// Shared constants and types for the Taylor-series evaluator.
package tss_pkg;

    localparam int TERM_LIMIT_DEF = 1024;
    localparam int XW   = 32;
    localparam int EPSW = 33;
    localparam int MODW = 2;
    localparam int CNTW = 11;

    localparam logic signed [63:0] PI_Q32     = 64'sd13493037705;
    localparam logic signed [63:0] TWO_PI_Q32 = 64'sd26986075409;
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [EPSW-1:0] EPS_RESET = 33'd4295;

    localparam logic [MODW-1:0] MODE_SIN = 2'd0;
    localparam logic [MODW-1:0] MODE_COS = 2'd1;

    // Multiplier operation request
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [63:0] prod;
    } mul_rsp_t;

    // Divider operation request
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [23:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

endpackage

FILE: sv/taylor_series_sin_cos_exp.sv
// Top level: sequencer for the Taylor-series sin/cos/exp evaluator.
//
//  channel | signals                               | direction | transfer when
//  cmd     | start, busy, mode, x_value, term_cap  | in        | start && !busy
//  cfg     | epsilon_valid, epsilon_ready, epsilon | in        | valid && ready
//  result  | done, approximation, term_count, sat. | out       | done (one cycle)
//
// Sin/cos argument reduction adds or subtracts 2*pi one step at a time
// (at most 3 steps), then the reduced argument is squared; exp skips both. Each
// further term is accumulated, multiplied in the shared multiplier and divided
// in the bit-serial divider. The last accumulate is followed by the output
// state and then the done strobe. Items run one at a time.
// Reset clears the sequencer and loads epsilon with about 1e-6.
// The receiver cannot stall: done is high for one cycle with the result.
module taylor_series_sin_cos_exp
    import tss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [MODW-1:0]        mode,
    input  logic signed [XW-1:0]   x_value,
    input  logic [CNTW-1:0]        term_cap,
    input  logic                   epsilon_valid,
    output logic                   epsilon_ready,
    input  logic [EPSW-1:0]        epsilon,
    output logic                   done,
    output logic signed [63:0]     approximation,
    output logic [CNTW-1:0]        term_count,
    output logic                   saturated
);

    localparam int TERM_LIMIT = TERM_LIMIT_DEF;
    localparam int LW = $clog2(TERM_LIMIT + 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_REDUCE = 7'b0000010,
        ST_SQ     = 7'b0000100,
        ST_ADD    = 7'b0001000,
        ST_MUL    = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [EPSW-1:0]   eps_reg;
    logic [MODW-1:0]   mode_reg;
    logic signed [63:0] arg_reg, arg_next;
    logic signed [63:0] sum_reg, sum_next;
    logic [63:0]       term_reg, term_next;
    logic [63:0]       mult_reg, mult_next;
    logic [LW-1:0]     idx_reg, idx_next;
    logic [LW-1:0]     lim_reg;
    logic              neg_reg, neg_next;
    logic              flip_reg, flip_next;
    logic              sat_reg, sat_next;
    logic              wait_reg, wait_next;
    logic              done_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    div_req_t dreq;
    div_rsp_t drsp;

    tss_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    tss_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Config register
    assign epsilon_ready = (state_reg == ST_IDLE);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (epsilon_valid && epsilon_ready)
            eps_reg <= epsilon;
    end

    // Term limit clamp
    logic [LW-1:0] lim_in;
    always_comb
    begin
        if (term_cap == '0)
            lim_in = LW'(1);
        else if ({1'b0, term_cap} > 12'(TERM_LIMIT))
            lim_in = LW'(TERM_LIMIT);
        else
            lim_in = LW'(term_cap);
    end

    logic [63:0] arg_mag;
    logic [11:0] k2;
    logic [23:0] den;
    logic [LW:0] idx_inc;
    logic signed [64:0] add_res;

    always_comb
    begin
        arg_mag = arg_reg[63] ? 64'(-arg_reg) : 64'(arg_reg);
        k2      = 12'({idx_reg, 1'b0});
        unique case (mode_reg)
            MODE_SIN: den = 24'(k2) * 24'(k2 + 12'd1);
            MODE_COS: den = 24'(k2 - 12'd1) * 24'(k2);
            default:  den = 24'(idx_reg);
        endcase
        idx_inc = {1'b0, idx_reg} + 1'b1;
        add_res = neg_reg ? 65'(sum_reg) - 65'(term_reg) : 65'(sum_reg) + 65'(term_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        arg_next   = arg_reg;
        sum_next   = sum_reg;
        term_next  = term_reg;
        mult_next  = mult_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        flip_next  = flip_reg;
        sat_next   = sat_reg;
        wait_next  = 1'b0;
        mreq       = '{start: 1'b0, a: term_reg, b: mult_reg};
        dreq       = '{start: 1'b0, num: mrsp.prod, den: den};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    arg_next   = 64'(signed'(x_value)) <<< 5;
                    sum_next   = '0;
                    idx_next   = '0;
                    sat_next   = 1'b0;
                    state_next = (mode[1] == 1'b0) ? ST_REDUCE : ST_ADD;
                    term_next  = ONE_Q32;
                    neg_next   = 1'b0;
                    flip_next  = x_value[XW-1];
                    mult_next  = x_value[XW-1] ? 64'(-(64'(signed'(x_value)) <<< 5))
                                               : 64'(64'(signed'(x_value)) <<< 5);
                end
            end
            ST_REDUCE:
            begin
                if (arg_reg > PI_Q32)
                    arg_next = arg_reg - TWO_PI_Q32;
                else if (arg_reg < -PI_Q32)
                    arg_next = arg_reg + TWO_PI_Q32;
                else
                begin
                    mreq.start = 1'b1;
                    mreq.a     = arg_mag;
                    mreq.b     = arg_mag;
                    flip_next  = 1'b1;
                    if (mode_reg == MODE_SIN)
                    begin
                        term_next = arg_mag;
                        neg_next  = arg_reg[63];
                    end
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (mrsp.done)
                begin
                    mult_next  = mrsp.prod;
                    sat_next   = sat_reg | mrsp.ovf;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (add_res > 65'sh0_7FFF_FFFF_FFFF_FFFF)
                begin
                    sum_next = 64'sh7FFF_FFFF_FFFF_FFFF;
                    sat_next = 1'b1;
                end
                else if (add_res < -65'sh0_8000_0000_0000_0000)
                begin
                    sum_next = 64'sh8000_0000_0000_0000;
                    sat_next = 1'b1;
                end
                else
                    sum_next = add_res[63:0];
                idx_next = idx_inc[LW-1:0];
                if ((idx_reg != '0 && term_reg < {31'd0, eps_reg})
                    || idx_inc >= {1'b0, lim_reg})
                    state_next = ST_OUT;
                else
                begin
                    mreq.start = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mrsp.done)
                begin
                    sat_next   = sat_reg | mrsp.ovf;
                    dreq.start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    term_next  = drsp.quo;
                    neg_next   = neg_reg ^ flip_reg;
                    state_next = ST_ADD;
                end
            end
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_OUT);
            wait_reg  <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_reg  <= arg_next;
        sum_reg  <= sum_next;
        term_reg <= term_next;
        mult_reg <= mult_next;
        idx_reg  <= idx_next;
        neg_reg  <= neg_next;
        flip_reg <= flip_next;
        sat_reg  <= sat_next;
        if (state_reg == ST_IDLE && start)
        begin
            mode_reg <= mode;
            lim_reg  <= lim_in;
        end
    end

    assign busy          = (state_reg != ST_IDLE) || wait_reg;
    assign done          = done_reg;
    assign approximation = sum_reg;
    assign term_count    = CNTW'(idx_reg);
    assign saturated     = sat_reg;

    // The result strobe is raised in the cycle after the output state
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_OUT))
        else $error("done without output state");

    // A divide is only started right after a multiply completes
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> mrsp.done)
        else $error("divide started without product");

    // The term count never exceeds the clamped limit
    a_lim: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (idx_reg <= lim_reg))
        else $error("term count above limit");

endmodule

FILE: sv/tss_mul.sv
// Sequential 64x64 unsigned Q31.32 multiplier built from one 32x32 partial product per cycle.
module tss_mul
    import tss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic [63:0]  pp_reg;
    logic [31:0]  opa, opb;
    logic [1:0]   sel;

    // Partial product selection
    always_comb
    begin
        sel = step_reg[1:0];
        opa = sel[0] ? a_reg[63:32] : a_reg[31:0];
        opb = sel[1] ? b_reg[63:32] : b_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= opa * opb;
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
    end

    // Accumulate the registered partial product in the cycle after it is selected
    always_comb
    begin
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 3'd1;
            if (step_reg != 3'd0)
            begin
                unique case (step_reg - 3'd1)
                    3'd0:    acc_next = acc_reg + {64'd0, pp_reg};
                    3'd1:    acc_next = acc_reg + {32'd0, pp_reg, 32'd0};
                    3'd2:    acc_next = acc_reg + {32'd0, pp_reg, 32'd0};
                    default: acc_next = acc_reg + {pp_reg, 64'd0};
                endcase
            end
            if (step_reg == 3'd4)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Done in the cycle after the last accumulation
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= busy_reg && (step_reg == 3'd4);
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = acc_reg[127:95] != '0;
    assign rsp.prod = (acc_reg[127:95] != '0) ? MAG_MAX : acc_reg[95:32];

endmodule

FILE: sv/tss_div.sv
// Restoring divider, one quotient bit per cycle, truncating.
module tss_div
    import tss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [63:0] quo_reg, quo_next;
    logic [23:0] rem_reg, rem_next;
    logic [23:0] den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 24'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[23:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (req.start)
            den_reg <= req.den;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

FILE: dv/taylor_series_sin_cos_exp_checker.sv
// Checker for the Taylor-series evaluator: tracks epsilon, predicts each result and compares.
module taylor_series_sin_cos_exp_checker
    import tss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [MODW-1:0]      mode,
    input  logic signed [XW-1:0] x_value,
    input  logic [CNTW-1:0]      term_cap,
    input  logic                 epsilon_valid,
    input  logic                 epsilon_ready,
    input  logic [EPSW-1:0]      epsilon,
    input  logic                 done,
    input  logic signed [63:0]   approximation,
    input  logic [CNTW-1:0]      term_count,
    input  logic                 saturated,
    output int                   fail_count,
    output int                   results_pending,
    output int                   results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [63:0] approx;
        logic [CNTW-1:0]    terms;
        logic               sat;
    } series_result_t;

    series_result_t sums_due[$];
    logic [EPSW-1:0] eps_shadow;

    // Truncated Q31.32 product of two magnitudes, clipped to 2^63-1
    function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b,
                                            inout logic sat);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:95] != '0)
        begin
            sat = 1'b1;
            return MAG_MAX;
        end
        return p[95:32];
    endfunction

    // Series evaluation for one command
    function automatic series_result_t series_eval(input logic [MODW-1:0] md,
                                                   input logic signed [XW-1:0] x,
                                                   input logic [CNTW-1:0] mt,
                                                   input logic [EPSW-1:0] eps);
        logic signed [63:0] r;
        logic signed [63:0] sum;
        logic signed [64:0] wide;
        logic [63:0] mag;
        logic [63:0] mult;
        logic [63:0] term;
        logic [63:0] divisor;
        logic neg;
        logic flip;
        logic sat;
        int lim;
        int n;
        series_result_t res;
        r = $signed({{27{x[31]}}, x, 5'b0});
        sat = 1'b0;
        lim = (mt == 0) ? 1 : ((mt > TERM_LIMIT_DEF) ? TERM_LIMIT_DEF : int'(mt));
        if (md == MODE_SIN || md == MODE_COS)
        begin
            while (r > PI_Q32) r = r - TWO_PI_Q32;
            while (r < -PI_Q32) r = r + TWO_PI_Q32;
            mag = (r < 0) ? 64'(-r) : 64'(r);
            mult = q32_mul(mag, mag, sat);
            flip = 1'b1;
            term = (md == MODE_SIN) ? mag : ONE_Q32;
            neg = (md == MODE_SIN) ? (r < 0) : 1'b0;
        end
        else
        begin
            mult = (r < 0) ? 64'(-r) : 64'(r);
            flip = (r < 0);
            term = ONE_Q32;
            neg = 1'b0;
        end
        sum = '0;
        n = 0;
        forever
        begin
            // saturating accumulate
            wide = neg ? ({sum[63], sum} - {1'b0, term}) : ({sum[63], sum} + {1'b0, term});
            if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            begin
                sum = 64'sh7FFF_FFFF_FFFF_FFFF;
                sat = 1'b1;
            end
            else if (wide < -65'sh0_8000_0000_0000_0000)
            begin
                sum = 64'sh8000_0000_0000_0000;
                sat = 1'b1;
            end
            else
                sum = wide[63:0];
            n++;
            if (n > 1 && term < {31'd0, eps}) break;
            if (n >= lim) break;
            if (md == MODE_SIN) divisor = 64'((2 * n) * (2 * n + 1));
            else if (md == MODE_COS) divisor = 64'((2 * n - 1) * (2 * n));
            else divisor = 64'(n);
            term = q32_mul(term, mult, sat) / divisor;
            if (flip) neg = !neg;
        end
        res.approx = sum;
        res.terms = n[CNTW-1:0];
        res.sat = sat;
        return res;
    endfunction

    // Track transfers on all three channels
    always @(posedge clk or negedge rst_n)
    begin
        series_result_t want;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            eps_shadow <= EPS_RESET;
            sums_due.delete();
            fail_count <= 0;
            results_checked <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (epsilon_valid && epsilon_ready)
                eps_shadow <= epsilon;
            if (start && !busy)
                sums_due.push_back(series_eval(mode, x_value, term_cap, eps_shadow));
            if (done)
            begin
                if (sums_due.size() == 0)
                begin
                    $error("result with nothing outstanding: approximation=%0d", approximation);
                    errs++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    results_checked <= results_checked + 1;
                    if (approximation !== want.approx)
                    begin
                        $error("approximation: expected %0d, got %0d", want.approx, approximation);
                        errs++;
                    end
                    if (term_count !== want.terms)
                    begin
                        $error("term_count: expected %0d, got %0d", want.terms, term_count);
                        errs++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $error("saturated: expected %0b, got %0b", want.sat, saturated);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            results_pending <= sums_due.size();
        end
    end

endmodule

FILE: dv/taylor_series_sin_cos_exp_tb.sv
// Testbench top for the Taylor-series evaluator: stimulus, epsilon phases and verdict.
module taylor_series_sin_cos_exp_tb
    import tss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODW-1:0] MODE_EXP  = 2'd2;
    localparam logic [MODW-1:0] MODE_RSVD = 2'd3;
    localparam int CYCLE_LIMIT = 100_000_000;
    localparam int ITEMS_PER_PHASE = 50;
    // Q5.27 pi, just below and above it
    localparam logic signed [XW-1:0] X_PI = 32'sd421657428;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [MODW-1:0] mode = '0;
    logic signed [XW-1:0] x_value = '0;
    logic [CNTW-1:0] term_cap = '0;
    logic epsilon_valid = 1'b0;
    logic epsilon_ready;
    logic [EPSW-1:0] epsilon = '0;
    logic done;
    logic signed [63:0] approximation;
    logic [CNTW-1:0] term_count;
    logic saturated;
    int fail_count;
    int results_pending;
    int results_checked;
    int cycle_count = 0;
    int items_sent = 0;
    int idle_pct = 0;

    always #6 clk = ~clk;

    taylor_series_sin_cos_exp dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .x_value(x_value), .term_cap(term_cap),
        .epsilon_valid(epsilon_valid), .epsilon_ready(epsilon_ready), .epsilon(epsilon),
        .done(done), .approximation(approximation), .term_count(term_count),
        .saturated(saturated)
    );

    taylor_series_sin_cos_exp_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .x_value(x_value), .term_cap(term_cap),
        .epsilon_valid(epsilon_valid), .epsilon_ready(epsilon_ready), .epsilon(epsilon),
        .done(done), .approximation(approximation), .term_count(term_count),
        .saturated(saturated), .fail_count(fail_count),
        .results_pending(results_pending), .results_checked(results_checked)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One command transfer; busy is stable at the falling edge
    task automatic issue(input logic [MODW-1:0] md, input logic signed [XW-1:0] x,
                         input logic [CNTW-1:0] mt);
        start = 1'b1;
        mode = md;
        x_value = x;
        term_cap = mt;
        while (busy) @(negedge clk);
        @(negedge clk);
        items_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    // Epsilon write once all results are back
    task automatic set_epsilon(input logic [EPSW-1:0] val);
        start = 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        epsilon_valid = 1'b1;
        epsilon = val;
        while (!epsilon_ready) @(negedge clk);
        @(negedge clk);
        epsilon_valid = 1'b0;
    endtask

    // Random items; long term counts kept rare, and left out entirely when short_only is set
    task automatic random_items(input int count, input bit short_only);
        logic signed [XW-1:0] x;
        logic [CNTW-1:0] mt;
        for (int i = 0; i < count; i++)
        begin
            x = $urandom_range(3) == 0 ? $signed(32'($urandom_range(0, 2 * X_PI)) - X_PI)
                                       : $signed($urandom());
            if (short_only || $urandom_range(9) != 0)
                mt = CNTW'($urandom_range(0, 40));
            else
                mt = CNTW'($urandom_range(0, 2047));
            issue(MODW'($urandom_range(0, 3)), x, mt);
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, every mode, reduction edges, term limit edges
        issue(MODE_SIN, 32'sd0, 11'd20);
        issue(MODE_SIN, 32'sh7FFF_FFFF, 11'd1024);
        issue(MODE_SIN, 32'sh8000_0000, 11'd1024);
        issue(MODE_SIN, X_PI, 11'd30);
        issue(MODE_SIN, X_PI + 1, 11'd30);
        issue(MODE_SIN, -X_PI - 1, 11'd30);
        issue(MODE_COS, 32'sd0, 11'd20);
        issue(MODE_COS, 32'sh7FFF_FFFF, 11'd2047);
        issue(MODE_COS, 32'sh8000_0000, 11'd0);
        issue(MODE_COS, -X_PI, 11'd30);
        issue(MODE_EXP, 32'sd0, 11'd10);
        issue(MODE_EXP, 32'sh7FFF_FFFF, 11'd1024);
        issue(MODE_EXP, 32'sh8000_0000, 11'd1024);
        issue(MODE_EXP, 32'sd134217728, 11'd1);
        issue(MODE_EXP, -32'sd134217728, 11'd0);
        issue(MODE_RSVD, 32'sd268435456, 11'd50);
        issue(MODE_RSVD, -32'sd268435456, 11'd2047);

        // Random phases across epsilon settings and sender idling
        idle_pct = 0;
        random_items(ITEMS_PER_PHASE, 1'b0);
        set_epsilon('0);
        issue(MODE_SIN, X_PI, 11'd1024);
        issue(MODE_EXP, 32'sh8000_0000, 11'd2047);
        idle_pct = 75;
        random_items(ITEMS_PER_PHASE, 1'b1);
        set_epsilon(33'h1_0000_0000);
        idle_pct = 0;
        random_items(ITEMS_PER_PHASE, 1'b0);
        set_epsilon(33'h1_FFFF_FFFF);
        idle_pct = 18;
        random_items(ITEMS_PER_PHASE / 2, 1'b0);
        set_epsilon(33'($urandom()));
        idle_pct = 75;
        random_items(ITEMS_PER_PHASE, 1'b0);
        set_epsilon(33'd1);
        idle_pct = 18;
        random_items(ITEMS_PER_PHASE / 2, 1'b1);
        set_epsilon(EPS_RESET);
        idle_pct = 0;
        random_items(ITEMS_PER_PHASE / 2, 1'b0);

        // Drain
        start = 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);

        $display("Ran %0d commands over all modes and seven epsilon settings; %0d results checked.",
                 items_sent, results_checked);
        if (fail_count == 0 && results_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
sv/tss_pkg.sv
sv/tss_mul.sv
sv/tss_div.sv
sv/taylor_series_sin_cos_exp.sv
dv/taylor_series_sin_cos_exp_checker.sv
dv/taylor_series_sin_cos_exp_tb.sv
